FILE: rtl/lppc_pkg.sv
// Shared types, constants and elaboration-time helpers of the palette colorizer.
`timescale 1ns / 1ps
`default_nettype none

package lppc_pkg;

    localparam int unsigned IN_FRAC_BITS = 16;
    localparam int unsigned FRAC_W       = 17;
    localparam int unsigned MAXIT_W      = 16;
    localparam int unsigned PROD_W       = 33;
    localparam int unsigned COLOR_W      = 24;
    localparam int unsigned LEVEL_W      = 8;
    localparam int unsigned CFG_IDX_W    = 3;

    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QPTR_W       = 2;
    localparam int unsigned QCNT_W       = 3;

    localparam logic [FRAC_W-1:0] ONE_IN = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_ZERO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_ONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_TWO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_THREE  = 3'd4;

    localparam logic [MAXIT_W-1:0] MAX_ITER_RESET  = 16'd256;
    localparam logic [COLOR_W-1:0] PAL_ZERO_RESET  = 24'h000000;
    localparam logic [COLOR_W-1:0] PAL_ONE_RESET   = 24'hFF0000;
    localparam logic [COLOR_W-1:0] PAL_TWO_RESET   = 24'h00FF00;
    localparam logic [COLOR_W-1:0] PAL_THREE_RESET = 24'h0000FF;

    // ln 2 in Q0.32
    localparam longint unsigned LN2_Q32 = 64'h00000000B17217F8;

    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed {
        logic              in_set;
        logic [PROD_W-1:0] prod;
    } lppc_item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } lppc_qstat_t;

    // Fixed-point log2 by repeated squaring; evaluated at elaboration only.
    function automatic longint unsigned log2_const(input int unsigned fb,
                                                   input longint unsigned v);
        int unsigned       e;
        longint unsigned   z;
        longint unsigned   res;
        e = 0;
        for (int i = 1; i < 64; i++) begin
            if ((v >> i) != 0) e = i;
        end
        if (e > 31) z = v >> (e - 31);
        else        z = v << (31 - e);
        res = longint'(e) << fb;
        for (int i = 1; i <= int'(fb); i++) begin
            z = (z * z) >> 31;
            if (z >= (64'd1 << 32)) begin
                z = z >> 1;
                res = res | (64'd1 << (fb - i));
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lppc_front.sv
// Front end: accept fraction words, flag inside-set points, form the log argument.
`timescale 1ns / 1ps
`default_nettype none

module lppc_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [lppc_pkg::FRAC_W-1:0]  frac,
    input  wire logic [lppc_pkg::MAXIT_W-1:0] max_iter,
    input  wire logic                       q_full,
    output logic                            push,
    output lppc_pkg::lppc_item_t            item
);
    import lppc_pkg::*;

    logic              front_valid_reg;
    logic              front_valid_next;
    lppc_item_t        item_reg;
    lppc_item_t        item_next;
    logic              take;
    logic [FRAC_W-1:0]  f_clamped;
    logic [MAXIT_W-1:0] m_clamped;

    assign s_tready = !front_valid_reg || !q_full;
    assign push     = front_valid_reg && !q_full;
    assign take     = s_tvalid && s_tready;
    assign item     = item_reg;

    always_comb begin
        // zero fraction counts as one LSB, zero limit as one
        f_clamped = (frac == '0) ? FRAC_W'(1) : frac;
        m_clamped = (max_iter == '0) ? MAXIT_W'(1) : max_iter;
        item_next.in_set = (frac == ONE_IN);
        item_next.prod   = PROD_W'(f_clamped) * PROD_W'(m_clamped);
        front_valid_next = take || (front_valid_reg && !push);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lppc_queue.sv
// Small FIFO between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none

module lppc_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire lppc_pkg::lppc_item_t item_in,
    input  wire logic                 pop,
    output logic                      q_valid,
    output lppc_pkg::lppc_item_t      item_out,
    output lppc_pkg::lppc_qstat_t     stat
);
    import lppc_pkg::*;

    lppc_item_t        mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wptr_next  = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = pop  ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign q_valid    = !stat.empty;
    assign item_out   = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lppc_log2.sv
// Pipelined fixed-point log2: leading-one search, normalize, one squaring per stage.
`timescale 1ns / 1ps
`default_nettype none

module lppc_log2 #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 ce,
    input  wire logic                 in_valid,
    input  wire lppc_pkg::lppc_item_t in_item,
    output logic                      out_valid,
    output logic                      out_inside,
    output logic [FRACTION_BITS+5:0]  out_res
);
    import lppc_pkg::*;

    localparam int unsigned EXP_W = 6;
    localparam int unsigned RES_W = FRACTION_BITS + EXP_W;

    logic              va_reg;
    logic              ins_a_reg;
    logic [EXP_W-1:0]  e_a_reg;
    logic [PROD_W-1:0] p_a_reg;
    logic [EXP_W-1:0]  e_next;
    logic [63:0]       shifted;

    logic [FRACTION_BITS:0] v_st_reg;
    logic [FRACTION_BITS:0] ins_st_reg;
    logic [31:0]      z_st_reg   [0:FRACTION_BITS];
    logic [RES_W-1:0] res_st_reg [0:FRACTION_BITS];
    logic [31:0]      z_next     [1:FRACTION_BITS];
    logic [RES_W-1:0] res_next   [1:FRACTION_BITS];
    logic [63:0]      sq         [1:FRACTION_BITS];
    logic [32:0]      sq_hi      [1:FRACTION_BITS];

    always_comb begin
        e_next = '0;
        for (int i = 0; i < int'(PROD_W); i++) begin
            if (in_item.prod[i]) e_next = EXP_W'(i);
        end
    end

    // mantissa to Q1.31
    assign shifted = {p_a_reg, 31'b0} >> e_a_reg;

    always_comb begin
        for (int g = 1; g <= int'(FRACTION_BITS); g++) begin
            sq[g]    = {32'b0, z_st_reg[g-1]} * {32'b0, z_st_reg[g-1]};
            sq_hi[g] = sq[g][63:31];
            if (sq_hi[g][32]) begin
                z_next[g]   = sq_hi[g][32:1];
                res_next[g] = res_st_reg[g-1] | (RES_W'(1) << (FRACTION_BITS - g));
            end else begin
                z_next[g]   = sq_hi[g][31:0];
                res_next[g] = res_st_reg[g-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg   <= 1'b0;
            v_st_reg <= '0;
        end else if (ce) begin
            va_reg   <= in_valid;
            v_st_reg <= {v_st_reg[FRACTION_BITS-1:0], va_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ins_a_reg     <= in_item.in_set;
            e_a_reg       <= e_next;
            p_a_reg       <= in_item.prod;
            ins_st_reg    <= {ins_st_reg[FRACTION_BITS-1:0], ins_a_reg};
            z_st_reg[0]   <= shifted[31:0];
            res_st_reg[0] <= {e_a_reg, {FRACTION_BITS{1'b0}}};
            for (int g = 1; g <= int'(FRACTION_BITS); g++) begin
                z_st_reg[g]   <= z_next[g];
                res_st_reg[g] <= res_next[g];
            end
        end
    end

    assign out_valid  = v_st_reg[FRACTION_BITS];
    assign out_inside = ins_st_reg[FRACTION_BITS];
    assign out_res    = res_st_reg[FRACTION_BITS];

endmodule

`default_nettype wire

FILE: rtl/lppc_back.sv
// Back end: phase from log2, palette pick, RMS blend and bit-serial root per stage.
`timescale 1ns / 1ps
`default_nettype none

module lppc_back #(
    parameter int unsigned PALETTE_ENTRIES = 4,
    parameter int unsigned FRACTION_BITS   = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           ce,
    input  wire logic                           in_valid,
    input  wire logic                           in_inside,
    input  wire logic [FRACTION_BITS+5:0]       in_res,
    input  wire lppc_pkg::color_t [3:0]         palette,
    output logic                                out_valid,
    output logic [lppc_pkg::LEVEL_W-1:0]        out_red,
    output logic [lppc_pkg::LEVEL_W-1:0]        out_green,
    output logic [lppc_pkg::LEVEL_W-1:0]        out_blue
);
    import lppc_pkg::*;

    localparam int unsigned F        = FRACTION_BITS;
    localparam int unsigned L_W      = F + 7;
    localparam int unsigned ABS_W    = F + 6;
    localparam int unsigned Y_W      = F + 6;
    localparam int unsigned K        = F + 9;
    localparam int unsigned RECIP_W  = F + 7;
    localparam int unsigned QP_W     = Y_W + K;
    localparam int unsigned X_W      = ABS_W + 32;
    localparam int unsigned SQ_W     = 2 * LEVEL_W;
    localparam int unsigned NSTAGE   = 7 + LEVEL_W;

    localparam longint unsigned C200    = log2_const(F, 200);
    localparam logic [L_W-1:0]  L_OFF   = L_W'(C200 + (64'(IN_FRAC_BITS) << F));
    localparam longint unsigned RECIP_L = ((64'd1 << K) + 64'd4) / 64'd5;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam logic [31:0]     LN2     = 32'(LN2_Q32);
    localparam logic [1:0]      IDX_MAX = 2'(PALETTE_ENTRIES - 2);
    localparam logic [F+1:0]    SCALE   = (F+2)'(PALETTE_ENTRIES - 1);

    logic [NSTAGE-1:0] v_reg;

    // stage 1
    logic [L_W-1:0]   diff, absd;
    logic             neg;
    logic [ABS_W-1:0] labs_reg;
    logic             pos1_reg, ins1_reg;
    // stage 2
    logic [X_W-1:0]   x_prod;
    logic [Y_W-1:0]   y_reg;
    logic             pos2_reg, ins2_reg;
    // stage 3
    logic [QP_W-1:0]  qp;
    logic [Y_W-1:0]   q_reg, y3_reg;
    logic             pos3_reg, ins3_reg;
    // stage 4
    logic [Y_W-1:0]   rem, mag;
    logic [F-1:0]     phase;
    logic [F+1:0]     s;
    logic [1:0]       idx;
    logic [F-1:0]     w4_reg;
    color_t           hi4_reg, lo4_reg;
    logic             ins4_reg;
    // stage 5
    logic [F-1:0]     w5_reg;
    logic [F:0]       wc5_reg;
    logic [SQ_W-1:0]  hsq_reg [0:2];
    logic [SQ_W-1:0]  lsq_reg [0:2];
    logic             ins5_reg;
    // stage 6
    logic [F+SQ_W-1:0] a_reg [0:2];
    logic [F+SQ_W:0]   b_reg [0:2];
    logic              ins6_reg;
    // stage 7 and root stages
    logic [F+SQ_W:0]     num [0:2];
    logic [SQ_W-1:0]     sx_reg [0:LEVEL_W][0:2];
    logic [LEVEL_W-1:0]  sr_reg [0:LEVEL_W][0:2];
    logic [LEVEL_W-1:0]  sr_next [1:LEVEL_W][0:2];
    logic [LEVEL_W-1:0]  trial [1:LEVEL_W][0:2];

    always_comb begin
        diff = {1'b0, in_res} - L_OFF;
        neg  = diff[L_W-1];
        absd = neg ? (L_W'(0) - diff) : diff;
    end

    assign x_prod = X_W'(labs_reg) * X_W'(LN2);
    assign qp     = QP_W'(y_reg) * QP_W'(RECIP);

    always_comb begin
        rem   = y3_reg - (q_reg + (q_reg << 2));
        mag   = (rem >= Y_W'(5)) ? q_reg + Y_W'(1) : q_reg;
        phase = pos3_reg ? (F'(0) - mag[F-1:0]) : mag[F-1:0];
        s     = {2'b00, phase} * SCALE;
        idx   = (s[F+1:F] > IDX_MAX) ? IDX_MAX : s[F+1:F];
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            num[c] = (F+SQ_W+1)'(a_reg[c]) + b_reg[c];
        end
        for (int k = 1; k <= int'(LEVEL_W); k++) begin
            for (int c = 0; c < 3; c++) begin
                trial[k][c] = sr_reg[k-1][c] | (LEVEL_W'(1) << (LEVEL_W - k));
                if (({8'b0, trial[k][c]} * {8'b0, trial[k][c]}) <= sx_reg[k-1][c]) begin
                    sr_next[k][c] = trial[k][c];
                end else begin
                    sr_next[k][c] = sr_reg[k-1][c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[NSTAGE-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            labs_reg <= absd[ABS_W-1:0];
            pos1_reg <= !neg && (diff != '0);
            ins1_reg <= in_inside;

            y_reg    <= x_prod[X_W-1:32];
            pos2_reg <= pos1_reg;
            ins2_reg <= ins1_reg;

            q_reg    <= qp[QP_W-1:K];
            y3_reg   <= y_reg;
            pos3_reg <= pos2_reg;
            ins3_reg <= ins2_reg;

            w4_reg   <= s[F-1:0];
            lo4_reg  <= palette[idx];
            hi4_reg  <= palette[idx + 2'd1];
            ins4_reg <= ins3_reg;

            w5_reg   <= w4_reg;
            wc5_reg  <= {1'b1, {F{1'b0}}} - {1'b0, w4_reg};
            ins5_reg <= ins4_reg;
            for (int c = 0; c < 3; c++) begin
                hsq_reg[c] <= {8'b0, hi4_reg[COLOR_W-1-LEVEL_W*c -: LEVEL_W]}
                            * {8'b0, hi4_reg[COLOR_W-1-LEVEL_W*c -: LEVEL_W]};
                lsq_reg[c] <= {8'b0, lo4_reg[COLOR_W-1-LEVEL_W*c -: LEVEL_W]}
                            * {8'b0, lo4_reg[COLOR_W-1-LEVEL_W*c -: LEVEL_W]};
            end

            ins6_reg <= ins5_reg;
            for (int c = 0; c < 3; c++) begin
                a_reg[c] <= (F+SQ_W)'(w5_reg) * (F+SQ_W)'(hsq_reg[c]);
                b_reg[c] <= (F+SQ_W+1)'(wc5_reg) * (F+SQ_W+1)'(lsq_reg[c]);
            end

            // inside-set points come out black
            for (int c = 0; c < 3; c++) begin
                sx_reg[0][c] <= ins6_reg ? '0 : num[c][F+SQ_W-1:F];
                sr_reg[0][c] <= '0;
            end

            for (int k = 1; k <= int'(LEVEL_W); k++) begin
                for (int c = 0; c < 3; c++) begin
                    sx_reg[k][c] <= sx_reg[k-1][c];
                    sr_reg[k][c] <= sr_next[k][c];
                end
            end
        end
    end

    assign out_valid = v_reg[NSTAGE-1];
    assign out_red   = sr_reg[LEVEL_W][0];
    assign out_green = sr_reg[LEVEL_W][1];
    assign out_blue  = sr_reg[LEVEL_W][2];

endmodule

`default_nettype wire

FILE: rtl/log_palette_pixel_colorizer_unit.sv
// Throughput: one pixel per cycle unless the output stalls; the back end is a single
// pipeline, one log2 squaring per stage and one root bit per stage.
// A four-word queue decouples the front end; a stalled output freezes the back end.
// Reset (synchronous, aresetn low): empties all stages and the queue, and loads the
// register defaults 256, 0x000000, 0xFF0000, 0x00FF00, 0x0000FF.
`timescale 1ns / 1ps
`default_nettype none

module log_palette_pixel_colorizer_unit #(
    parameter int unsigned PALETTE_ENTRIES = 4,
    parameter int unsigned FRACTION_BITS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [16:0] escape_fraction, rest zero
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] red_level, [15:8] green_level, [23:16] blue_level
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import lppc_pkg::*;

    logic [MAXIT_W-1:0]     max_iter_reg, max_iter_next;
    color_t [3:0]           palette_reg, palette_next;
    logic                   cfg_write;

    logic                   q_push;
    lppc_item_t             front_item;
    logic                   q_valid;
    logic                   q_pop;
    lppc_item_t             q_item;
    lppc_qstat_t            q_stat;

    logic                   ce;
    logic                   log_valid;
    logic                   log_inside;
    logic [FRACTION_BITS+5:0] log_res;
    logic [LEVEL_W-1:0]     red_level, green_level, blue_level;

    // Configuration is always accepted; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        max_iter_next = max_iter_reg;
        palette_next  = palette_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_MAX_ITER:  max_iter_next   = cfg_data[MAXIT_W-1:0];
                REG_PAL_ZERO:  palette_next[0] = cfg_data;
                REG_PAL_ONE:   palette_next[1] = cfg_data;
                REG_PAL_TWO:   palette_next[2] = cfg_data;
                REG_PAL_THREE: palette_next[3] = cfg_data;
                default:       max_iter_next   = max_iter_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg   <= MAX_ITER_RESET;
            palette_reg[0] <= PAL_ZERO_RESET;
            palette_reg[1] <= PAL_ONE_RESET;
            palette_reg[2] <= PAL_TWO_RESET;
            palette_reg[3] <= PAL_THREE_RESET;
        end else begin
            max_iter_reg   <= max_iter_next;
            palette_reg    <= palette_next;
        end
    end

    // Front end: take a word whenever its holding register is free or draining.
    lppc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .frac     (s_tdata[FRAC_W-1:0]),
        .max_iter (max_iter_reg),
        .q_full   (q_stat.full),
        .push     (q_push),
        .item     (front_item)
    );

    lppc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .item_in  (front_item),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .item_out (q_item),
        .stat     (q_stat)
    );

    // Back end advances as a whole unless a finished pixel waits on the output.
    assign ce    = !m_tvalid || m_tready;
    assign q_pop = ce && q_valid;

    lppc_log2 #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_log2 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (q_valid),
        .in_item    (q_item),
        .out_valid  (log_valid),
        .out_inside (log_inside),
        .out_res    (log_res)
    );

    lppc_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (log_valid),
        .in_inside (log_inside),
        .in_res    (log_res),
        .palette   (palette_reg),
        .out_valid (m_tvalid),
        .out_red   (red_level),
        .out_green (green_level),
        .out_blue  (blue_level)
    );

    assign m_tdata = {blue_level, green_level, red_level};

    // Queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_cfg_maxit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_index == REG_MAX_ITER)
        |=> max_iter_reg == $past(cfg_data[MAXIT_W-1:0]))
        else $error("iteration limit write lost");

endmodule

`default_nettype wire

FILE: dv/lppc_checker.sv
// Pixel checker: predicts each colorized pixel from accepted words and compares results.
`timescale 1ns / 1ps

module lppc_checker #(
    parameter int unsigned PALETTE_ENTRIES = 4,
    parameter int unsigned FRACTION_BITS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               pixels_seen
);
    import lppc_pkg::*;

    localparam longint unsigned FMASK = (64'd1 << FRACTION_BITS) - 1;

    logic [MAXIT_W-1:0] iter_limit;
    color_t             colors [4];
    logic [23:0]        pixel_queue [$];

    function automatic longint unsigned fix_log2(longint unsigned v);
        int unsigned     e;
        longint unsigned z, res;
        if (v == 0) v = 1;
        e = 0;
        while (e < 63 && (v >> (e + 1)) != 0) e++;
        z = (e > 31) ? (v >> (e - 31)) : (v << (31 - e));
        res = longint'(e) << FRACTION_BITS;
        for (int i = 1; i <= FRACTION_BITS; i++) begin
            z = (z * z) >> 31;
            if (z >= (64'd1 << 32)) begin
                z = z >> 1;
                res = res | (64'd1 << (FRACTION_BITS - i));
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] blend_level(logic [7:0] hi, logic [7:0] lo,
                                               longint unsigned w);
        longint unsigned num;
        logic [31:0]     x, r, t;
        num = w * (hi * hi) + ((64'd1 << FRACTION_BITS) - w) * (lo * lo);
        x = 32'(num >> FRACTION_BITS);
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (t * t <= x) r = t;
        end
        return r[7:0];
    endfunction

    function automatic logic [23:0] colorize(logic [16:0] frac);
        longint unsigned f, p, mag, phase, s, w, labs, m;
        longint          l;
        int unsigned     idx;
        logic [23:0]     pix;
        logic [7:0]      hi, lo;
        if (frac == ONE_IN) return 24'd0;
        f = (frac == 0) ? 1 : frac;
        m = (iter_limit == 0) ? 1 : iter_limit;
        p = f * m;
        l = longint'(fix_log2(p)) - longint'(fix_log2(200))
          - longint'(64'd16 << FRACTION_BITS);
        labs = (l < 0) ? longint'(-l) : l;
        mag = ((labs * LN2_Q32) / 5) >> 32;
        phase = (l > 0) ? (((64'd1 << FRACTION_BITS) - (mag & FMASK)) & FMASK)
                        : (mag & FMASK);
        s = phase * (PALETTE_ENTRIES - 1);
        idx = s >> FRACTION_BITS;
        w = s & FMASK;
        if (idx > PALETTE_ENTRIES - 2) idx = PALETTE_ENTRIES - 2;
        idx = idx & 3;
        for (int ch = 0; ch < 3; ch++) begin
            hi = colors[(idx + 1) & 3][16 - 8*ch +: 8];
            lo = colors[idx][16 - 8*ch +: 8];
            pix[8*ch +: 8] = blend_level(hi, lo, w);   // red lowest in tdata
        end
        return pix;
    endfunction

    always_ff @(posedge aclk) begin
        logic [23:0] want;
        int          errs;
        errs = 0;
        if (!aresetn) begin
            iter_limit <= MAX_ITER_RESET;
            colors[0]  <= PAL_ZERO_RESET;
            colors[1]  <= PAL_ONE_RESET;
            colors[2]  <= PAL_TWO_RESET;
            colors[3]  <= PAL_THREE_RESET;
            fail_count <= 0;
            pixels_seen <= 0;
            pixel_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAX_ITER:  iter_limit <= cfg_data[15:0];
                    REG_PAL_ZERO:  colors[0] <= cfg_data;
                    REG_PAL_ONE:   colors[1] <= cfg_data;
                    REG_PAL_TWO:   colors[2] <= cfg_data;
                    REG_PAL_THREE: colors[3] <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) pixel_queue.push_back(colorize(s_tdata[16:0]));
            if (m_tvalid && m_tready) begin
                pixels_seen <= pixels_seen + 1;
                if (pixel_queue.size() == 0) begin
                    $error("unexpected pixel %h", m_tdata);
                    errs = errs + 1;
                end else begin
                    want = pixel_queue.pop_front();
                    if (want[7:0] != m_tdata[7:0]) begin
                        $error("red_level exp %0d got %0d", want[7:0], m_tdata[7:0]);
                        errs = errs + 1;
                    end
                    if (want[15:8] != m_tdata[15:8]) begin
                        $error("green_level exp %0d got %0d", want[15:8], m_tdata[15:8]);
                        errs = errs + 1;
                    end
                    if (want[23:16] != m_tdata[23:16]) begin
                        $error("blue_level exp %0d got %0d", want[23:16], m_tdata[23:16]);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

    assign pending = pixel_queue.size();

endmodule

FILE: dv/tb_top.sv
// Top of the colorizer testbench: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_top;
    import lppc_pkg::*;

    localparam int LATENCY   = 34;
    localparam int CYCLE_CAP = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    int          fail_count, pending, pixels_seen;
    int          cycle_count;
    bit          calm;          // long stretch with no idling on either side

    log_palette_pixel_colorizer_unit dut (.*);

    lppc_checker chk (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Count cycles; give up well past the slowest correct run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_CAP) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: stall at random, about 21 percent of the time, unless calm.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 21);
    end

    // Drive one word, idling at random before it, and hold until accepted.
    task automatic send_word(logic [16:0] frac);
        while (!calm && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, frac};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Lower valid, then hold until every pixel is back and the pipe is drained.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Random fraction: mostly typical escape values, some edges and above-one values.
    function automatic logic [16:0] pick_fraction();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return 17'd0;
        if (r < 10) return ONE_IN;
        if (r < 20) return 17'($urandom_range(131071, 65537));
        if (r < 30) return 17'($urandom_range(63));
        return 17'($urandom_range(65535));
    endfunction

    task automatic random_palette();
        write_reg(REG_MAX_ITER, 24'($urandom_range(65535)));
        write_reg(REG_PAL_ZERO, 24'($urandom));
        write_reg(REG_PAL_ONE, 24'($urandom));
        write_reg(REG_PAL_TWO, 24'($urandom));
        write_reg(REG_PAL_THREE, 24'($urandom));
    endtask

    initial begin
        logic [16:0] directed [$];
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        calm      = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: inside point, zero, above one, extremes and bit walks.
        directed = '{ONE_IN, 17'd0, 17'd1, 17'd2, 17'h0FFFF, 17'h10001, 17'h1FFFF,
                     17'h08000, 17'h00100, 17'h00C8, 17'h15555, 17'h0AAAA};
        foreach (directed[i]) send_word(directed[i]);
        drain();

        // Extreme registers; zero iteration limit behaves as one.
        write_reg(REG_MAX_ITER, 24'd0);
        write_reg(REG_PAL_ZERO, 24'hFFFFFF);
        write_reg(REG_PAL_ONE, 24'h000000);
        write_reg(REG_PAL_TWO, 24'hFFFFFF);
        write_reg(REG_PAL_THREE, 24'h000000);
        write_reg(3'd7, 24'h123456);      // unused index, ignored
        foreach (directed[i]) send_word(directed[i]);
        drain();
        write_reg(REG_MAX_ITER, 24'hFFFFFF);  // upper bits drop, limit 65535
        send_word(17'h1FFFF);
        send_word(17'd0);
        send_word(17'd200);
        drain();

        // Random phases, each with fresh register settings.
        for (int ph = 0; ph < 13; ph++) begin
            random_palette();
            calm = (ph == 4);
            repeat (100) send_word(pick_fraction());
            drain();
        end
        calm = 1'b0;

        drain();
        $display("Ran %0d pixels: directed edges, inside/zero/over-one fractions,", pixels_seen);
        $display("extreme and random palettes and iteration limits, with random stalls.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
